@@ src/otcg_pkg.sv @@
`default_nettype none

package otcg_pkg;

    // Upper limits on the page and cell counts taken from the panel size.
    localparam int MAX_PAGES = 8;
    localparam int MAX_CELLS = 16;

    // Number of transaction groups one command can expand into.
    localparam int NUM_SEGS = 4;

    // Input command codes.
    typedef enum logic [3:0] {
        CMD_MOVE              = 4'd0,
        CMD_NEXT_ROW          = 4'd1,
        CMD_NEXT_ROW_DOUBLE   = 4'd2,
        CMD_DRAW              = 4'd3,
        CMD_CLEAR_ROW         = 4'd4,
        CMD_CLEAR_ROW_DOUBLE  = 4'd5,
        CMD_CLEAR_REST        = 4'd6,
        CMD_CLEAR_REST_DOUBLE = 4'd7,
        CMD_CLEAR_ALL         = 4'd8,
        CMD_POWER             = 4'd9,
        CMD_INVERT            = 4'd10,
        CMD_FLIP              = 4'd11,
        CMD_CONTRAST          = 4'd12
    } command_t;

    // Transaction kinds on the result channel.
    typedef enum logic [2:0] {
        KIND_CMD1 = 3'd0,
        KIND_CMD2 = 3'd1,
        KIND_DATA = 3'd2,
        KIND_ZERO = 3'd3,
        KIND_NONE = 3'd4
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_PANEL_WIDTH    = 2'd1,
        REG_PANEL_HEIGHT   = 2'd2
    } cfg_reg_t;

    // Kinds of transaction groups handed from the front to the back.
    typedef enum logic [2:0] {
        SEG_NONE        = 3'd0,
        SEG_CMD         = 3'd1,
        SEG_CMD2        = 3'd2,
        SEG_POS         = 3'd3,
        SEG_FILL        = 3'd4,
        SEG_DATA_TOP    = 3'd5,
        SEG_DATA_BOTTOM = 3'd6,
        SEG_ALL_PAGES   = 3'd7
    } seg_kind_t;

    // One transaction group. For a position group row and cell give the target;
    // for the all-pages group row holds the page count and value the fill length.
    typedef struct packed {
        seg_kind_t   kind;
        logic [7:0]  value;
        logic [3:0]  row;
        logic [4:0]  cell_idx;
    } seg_t;

    // One classified command as it waits in the queue.
    typedef struct packed {
        seg_t [NUM_SEGS-1:0] segs;
        logic [1:0]          last_seg;
        logic                success;
        logic [63:0]         top;
        logic [63:0]         bottom;
    } job_t;

    // Panel geometry derived from the configuration registers.
    typedef struct packed {
        logic [3:0] pages;
        logic [4:0] cells;
    } geometry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_RUN  = 1'b1
    } back_state_t;

    // Controller command bytes and nibbles.
    localparam logic [3:0] PAGE_NIBBLE     = 4'hB;
    localparam logic [3:0] COL_LOW_NIBBLE  = 4'h0;
    localparam logic [3:0] COL_HIGH_NIBBLE = 4'h1;
    localparam logic [7:0] OP_CONTRAST     = 8'h81;
    localparam logic [7:0] OP_DISPLAY_ON   = 8'hAF;
    localparam logic [7:0] OP_DISPLAY_OFF  = 8'hAE;
    localparam logic [7:0] OP_INVERT_ON    = 8'hA7;
    localparam logic [7:0] OP_INVERT_OFF   = 8'hA6;
    localparam logic [7:0] OP_REMAP_ON     = 8'hA1;
    localparam logic [7:0] OP_REMAP_OFF    = 8'hA0;
    localparam logic [7:0] OP_SCAN_DEC     = 8'hC8;
    localparam logic [7:0] OP_SCAN_INC     = 8'hC0;

endpackage

`default_nettype wire

@@ src/otcg_front.sv @@
`default_nettype none

module otcg_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    output logic                          cmd_stall,
    input  wire logic [3:0]               command,
    input  wire logic [3:0]               target_row,
    input  wire logic [4:0]               target_column,
    input  wire logic [63:0]              glyph_top,
    input  wire logic [63:0]              glyph_bottom,
    input  wire logic                     glyph_tall,
    input  wire logic [7:0]               setting_value,
    input  wire otcg_pkg::geometry_t      geom,
    input  wire otcg_pkg::queue_status_t  qstat,
    output logic                          push,
    output otcg_pkg::job_t                job
);

    logic [2:0] row_reg;
    logic [2:0] row_next;
    logic [4:0] cell_reg;
    logic [4:0] cell_next;

    otcg_pkg::seg_t [otcg_pkg::NUM_SEGS-1:0] segs;
    logic [2:0] seg_cnt;
    logic       ok;

    logic [2:0] nr_move;
    logic [4:0] nc_move;
    logic       move_ok;
    logic [3:0] row_inc1;
    logic [3:0] row_inc2;
    logic [3:0] next_target;
    logic [5:0] cell_inc;
    logic [7:0] full_fill;
    logic [7:0] rest_fill;
    logic [4:0] rest_cells;
    logic       clear_first_ok;
    logic       clear_second_ok;
    logic       rest_far_ok;
    logic       rest_near_ok;

    function automatic otcg_pkg::seg_t make_seg(
        input otcg_pkg::seg_kind_t kind,
        input logic [7:0]          value,
        input logic [3:0]          row,
        input logic [4:0]          cell_idx
    );
        otcg_pkg::seg_t s;
        s.kind     = kind;
        s.value    = value;
        s.row      = row;
        s.cell_idx = cell_idx;
        return s;
    endfunction

    // Handshake: a transfer is taken whenever the queue has room.
    assign cmd_stall = qstat.full;
    assign push      = cmd_valid && !qstat.full;

    // Targets and range checks for the cursor moves a command can make.
    assign nr_move   = (target_row == 4'd0) ? row_reg : 3'(target_row - 4'd1);
    assign nc_move   = (target_column == 5'd0) ? cell_reg : (target_column - 5'd1);
    assign move_ok   = (target_row <= geom.pages) && (target_column <= geom.cells);
    assign row_inc1  = {1'b0, row_reg} + 4'd1;
    assign row_inc2  = {1'b0, row_reg} + 4'd2;
    assign next_target = (command == otcg_pkg::CMD_NEXT_ROW) ? row_inc1 : row_inc2;
    assign cell_inc  = {1'b0, cell_reg} + 6'd1;
    assign full_fill = {geom.cells, 3'b000};
    assign rest_cells = geom.cells - cell_reg;
    assign rest_fill = (cell_reg >= geom.cells) ? 8'd0 : {rest_cells, 3'b000};
    assign clear_first_ok  = (target_row <= geom.pages) && (geom.cells != 5'd0);
    assign clear_second_ok = ({1'b0, target_row} + 5'd1) <= {1'b0, geom.pages};
    assign rest_far_ok  = (row_inc2 <= geom.pages) && (cell_inc <= {1'b0, geom.cells});
    assign rest_near_ok = (row_inc1 <= geom.pages) && (cell_inc <= {1'b0, geom.cells});

    // Command decoder: expand the command into transaction groups and the new cursor.
    always_comb
    begin
        segs      = '0;
        seg_cnt   = 3'd0;
        ok        = 1'b1;
        row_next  = row_reg;
        cell_next = cell_reg;
        unique case (command) inside
            otcg_pkg::CMD_MOVE:
            begin
                if (move_ok)
                begin
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_POS, 8'd0,
                                                  {1'b0, nr_move}, nc_move);
                    seg_cnt = seg_cnt + 3'd1;
                    row_next  = nr_move;
                    cell_next = nc_move;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            otcg_pkg::CMD_NEXT_ROW, otcg_pkg::CMD_NEXT_ROW_DOUBLE:
            begin
                if (next_target < geom.pages)
                begin
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_POS, 8'd0,
                                                  next_target, 5'd0);
                    seg_cnt = seg_cnt + 3'd1;
                    row_next  = next_target[2:0];
                    cell_next = 5'd0;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            otcg_pkg::CMD_DRAW:
            begin
                if (cell_reg < geom.cells)
                begin
                    // A tall glyph writes the page below first, then returns.
                    if (glyph_tall)
                    begin
                        segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_CMD,
                                                      {otcg_pkg::PAGE_NIBBLE, row_inc1},
                                                      4'd0, 5'd0);
                        seg_cnt = seg_cnt + 3'd1;
                        segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_DATA_BOTTOM, 8'd0,
                                                      4'd0, 5'd0);
                        seg_cnt = seg_cnt + 3'd1;
                        segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_POS, 8'd0,
                                                      {1'b0, row_reg}, cell_reg);
                        seg_cnt = seg_cnt + 3'd1;
                    end
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_DATA_TOP, 8'd0,
                                                  4'd0, 5'd0);
                    seg_cnt = seg_cnt + 3'd1;
                    cell_next = cell_reg + 5'd1;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            otcg_pkg::CMD_CLEAR_ROW, otcg_pkg::CMD_CLEAR_ROW_DOUBLE:
            begin
                if (clear_first_ok)
                begin
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_POS, 8'd0,
                                                  {1'b0, nr_move}, 5'd0);
                    seg_cnt = seg_cnt + 3'd1;
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_FILL, full_fill,
                                                  4'd0, 5'd0);
                    seg_cnt = seg_cnt + 3'd1;
                    row_next  = nr_move;
                    cell_next = 5'd0;
                    // The second row is taken from the raw target, one page lower.
                    if (command == otcg_pkg::CMD_CLEAR_ROW_DOUBLE)
                    begin
                        if (clear_second_ok)
                        begin
                            segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_POS, 8'd0,
                                                          target_row, 5'd0);
                            seg_cnt = seg_cnt + 3'd1;
                            segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_FILL, full_fill,
                                                          4'd0, 5'd0);
                            seg_cnt = seg_cnt + 3'd1;
                            row_next = target_row[2:0];
                        end
                        else
                        begin
                            ok = 1'b0;
                        end
                    end
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            otcg_pkg::CMD_CLEAR_REST, otcg_pkg::CMD_CLEAR_REST_DOUBLE:
            begin
                segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_FILL, rest_fill, 4'd0, 5'd0);
                seg_cnt = seg_cnt + 3'd1;
                // Moves that fall off the panel are skipped without failing.
                if (command == otcg_pkg::CMD_CLEAR_REST_DOUBLE)
                begin
                    if (rest_far_ok)
                    begin
                        segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_POS, 8'd0,
                                                      row_inc1, cell_reg);
                        seg_cnt = seg_cnt + 3'd1;
                        row_next  = row_inc1[2:0];
                        cell_next = cell_reg;
                    end
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_FILL, rest_fill,
                                                  4'd0, 5'd0);
                    seg_cnt = seg_cnt + 3'd1;
                end
                if (rest_near_ok)
                begin
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_POS, 8'd0,
                                                  {1'b0, row_reg}, cell_reg);
                    seg_cnt = seg_cnt + 3'd1;
                    row_next  = row_reg;
                    cell_next = cell_reg;
                end
            end
            otcg_pkg::CMD_CLEAR_ALL:
            begin
                if (geom.pages != 4'd0)
                begin
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_ALL_PAGES, full_fill,
                                                  geom.pages, 5'd0);
                    seg_cnt = seg_cnt + 3'd1;
                end
                if ((geom.pages != 4'd0) && (geom.cells != 5'd0))
                begin
                    segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_POS, 8'd0, 4'd0, 5'd0);
                    seg_cnt = seg_cnt + 3'd1;
                    row_next  = 3'd0;
                    cell_next = 5'd0;
                end
            end
            otcg_pkg::CMD_POWER:
            begin
                segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_CMD,
                    setting_value[0] ? otcg_pkg::OP_DISPLAY_ON : otcg_pkg::OP_DISPLAY_OFF,
                    4'd0, 5'd0);
                seg_cnt = seg_cnt + 3'd1;
            end
            otcg_pkg::CMD_INVERT:
            begin
                segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_CMD,
                    setting_value[0] ? otcg_pkg::OP_INVERT_ON : otcg_pkg::OP_INVERT_OFF,
                    4'd0, 5'd0);
                seg_cnt = seg_cnt + 3'd1;
            end
            otcg_pkg::CMD_FLIP:
            begin
                segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_CMD,
                    setting_value[0] ? otcg_pkg::OP_REMAP_ON : otcg_pkg::OP_REMAP_OFF,
                    4'd0, 5'd0);
                seg_cnt = seg_cnt + 3'd1;
                segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_CMD,
                    setting_value[0] ? otcg_pkg::OP_SCAN_DEC : otcg_pkg::OP_SCAN_INC,
                    4'd0, 5'd0);
                seg_cnt = seg_cnt + 3'd1;
            end
            otcg_pkg::CMD_CONTRAST:
            begin
                segs[seg_cnt[1:0]] = make_seg(otcg_pkg::SEG_CMD2, setting_value,
                                              4'd0, 5'd0);
                seg_cnt = seg_cnt + 3'd1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        // A command with nothing to send still reports once.
        if (seg_cnt == 3'd0)
        begin
            segs[0] = make_seg(otcg_pkg::SEG_NONE, 8'd0, 4'd0, 5'd0);
            seg_cnt = 3'd1;
        end
    end

    // Job handed to the queue.
    always_comb
    begin
        job.segs     = segs;
        job.last_seg = 2'(seg_cnt - 3'd1);
        job.success  = ok;
        job.top      = glyph_top;
        job.bottom   = glyph_bottom;
    end

    // Cursor moves as soon as the command is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= 3'd0;
            cell_reg <= 5'd0;
        end
        else if (push)
        begin
            row_reg  <= row_next;
            cell_reg <= cell_next;
        end
    end

endmodule

`default_nettype wire

@@ src/otcg_queue.sv @@
`default_nettype none

module otcg_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire otcg_pkg::job_t           push_job,
    input  wire logic                     pop,
    output otcg_pkg::job_t                pop_job,
    output otcg_pkg::queue_status_t       qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    otcg_pkg::job_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign pop_job     = entries[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/otcg_back.sv @@
`default_nettype none

module otcg_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire otcg_pkg::queue_status_t  qstat,
    input  wire otcg_pkg::job_t           pop_job,
    output logic                          pop,
    input  wire logic [6:0]               device_address,
    output logic                          txn_valid,
    input  wire logic                     txn_stall,
    output logic [2:0]                    transaction_kind,
    output logic [6:0]                    bus_address,
    output logic [7:0]                    command_byte,
    output logic [7:0]                    argument_byte,
    output logic [63:0]                   data_bytes,
    output logic [7:0]                    zero_count,
    output logic                          success,
    output logic                          last
);

    otcg_pkg::back_state_t state_reg;
    otcg_pkg::back_state_t state_next;
    otcg_pkg::job_t        job_reg;
    logic [1:0]            seg_idx_reg;
    logic [1:0]            seg_idx_next;
    logic [3:0]            sub_reg;
    logic [3:0]            sub_next;

    otcg_pkg::seg_t        cur;
    otcg_pkg::kind_t       kind;
    logic [7:0]            cmd;
    logic [7:0]            arg;
    logic [63:0]           data;
    logic [7:0]            zc;
    logic                  seg_done;
    logic                  is_last;
    logic                  slot_free;
    logic                  load_out;

    otcg_pkg::kind_t       kind_reg;
    logic                  txn_valid_reg;
    logic [6:0]            address_reg;
    logic [7:0]            cmd_reg;
    logic [7:0]            arg_reg;
    logic [63:0]           data_reg;
    logic [7:0]            zc_reg;
    logic                  success_reg;
    logic                  last_reg;

    assign cur       = job_reg.segs[seg_idx_reg];
    assign slot_free = !txn_valid_reg || !txn_stall;

    // Result generator for the current step of the current group.
    always_comb
    begin
        kind     = otcg_pkg::KIND_NONE;
        cmd      = 8'd0;
        arg      = 8'd0;
        data     = 64'd0;
        zc       = 8'd0;
        seg_done = 1'b1;
        unique case (cur.kind)
            otcg_pkg::SEG_NONE:
            begin
                kind = otcg_pkg::KIND_NONE;
            end
            otcg_pkg::SEG_CMD:
            begin
                kind = otcg_pkg::KIND_CMD1;
                cmd  = cur.value;
            end
            otcg_pkg::SEG_CMD2:
            begin
                kind = otcg_pkg::KIND_CMD2;
                cmd  = otcg_pkg::OP_CONTRAST;
                arg  = cur.value;
            end
            otcg_pkg::SEG_POS:
            begin
                // Page, then low and high column nibbles of cell times eight.
                kind = otcg_pkg::KIND_CMD1;
                if (sub_reg == 4'd0)
                begin
                    cmd = {otcg_pkg::PAGE_NIBBLE, cur.row};
                end
                else if (sub_reg == 4'd1)
                begin
                    cmd = {otcg_pkg::COL_LOW_NIBBLE, cur.cell_idx[0], 3'b000};
                end
                else
                begin
                    cmd = {otcg_pkg::COL_HIGH_NIBBLE, cur.cell_idx[4:1]};
                end
                seg_done = (sub_reg == 4'd2);
            end
            otcg_pkg::SEG_FILL:
            begin
                kind = otcg_pkg::KIND_ZERO;
                zc   = cur.value;
            end
            otcg_pkg::SEG_DATA_TOP:
            begin
                kind = otcg_pkg::KIND_DATA;
                data = job_reg.top;
            end
            otcg_pkg::SEG_DATA_BOTTOM:
            begin
                kind = otcg_pkg::KIND_DATA;
                data = job_reg.bottom;
            end
            otcg_pkg::SEG_ALL_PAGES:
            begin
                // Even steps select a page, odd steps fill it.
                if (!sub_reg[0])
                begin
                    kind = otcg_pkg::KIND_CMD1;
                    cmd  = {otcg_pkg::PAGE_NIBBLE, 1'b0, sub_reg[3:1]};
                end
                else
                begin
                    kind = otcg_pkg::KIND_ZERO;
                    zc   = cur.value;
                end
                seg_done = (sub_reg == 4'({cur.row, 1'b0} - 5'd1));
            end
            default:
            begin
                kind = otcg_pkg::KIND_NONE;
            end
        endcase
    end

    assign is_last = seg_done && (seg_idx_reg == job_reg.last_seg);

    // Sequencer: take a job, walk its groups one transfer per free cycle.
    always_comb
    begin
        state_next   = state_reg;
        seg_idx_next = seg_idx_reg;
        sub_next     = sub_reg;
        pop          = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            otcg_pkg::BACK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop          = 1'b1;
                    seg_idx_next = 2'd0;
                    sub_next     = 4'd0;
                    state_next   = otcg_pkg::BACK_RUN;
                end
            end
            otcg_pkg::BACK_RUN:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    if (is_last)
                    begin
                        state_next = otcg_pkg::BACK_IDLE;
                    end
                    else if (seg_done)
                    begin
                        seg_idx_next = seg_idx_reg + 2'd1;
                        sub_next     = 4'd0;
                    end
                    else
                    begin
                        sub_next = sub_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = otcg_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= otcg_pkg::BACK_IDLE;
            seg_idx_reg   <= 2'd0;
            sub_reg       <= 4'd0;
            txn_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seg_idx_reg <= seg_idx_next;
            sub_reg     <= sub_next;
            if (load_out)
            begin
                txn_valid_reg <= 1'b1;
            end
            else if (!txn_stall)
            begin
                txn_valid_reg <= 1'b0;
            end
        end
    end

    // Job and output payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_job;
        end
        if (load_out)
        begin
            kind_reg    <= kind;
            address_reg <= device_address;
            cmd_reg     <= cmd;
            arg_reg     <= arg;
            data_reg    <= data;
            zc_reg      <= zc;
            success_reg <= job_reg.success;
            last_reg    <= is_last;
        end
    end

    assign txn_valid        = txn_valid_reg;
    assign transaction_kind = kind_reg;
    assign bus_address      = address_reg;
    assign command_byte     = cmd_reg;
    assign argument_byte    = arg_reg;
    assign data_bytes       = data_reg;
    assign zero_count       = zc_reg;
    assign success          = success_reg;
    assign last             = last_reg;

endmodule

`default_nettype wire

@@ src/oled_text_cursor_command_generator_top.sv @@
// A taken command is written into the job queue, fetched into the back's job register, and
// then issued as registered transfers; a command yields 1 to 19 transfers, and the back
// sequencer takes no new job from the queue until the current job's last transfer is issued.
// The input side takes a command per cycle until the job queue (QUEUE_DEPTH entries) fills.
// Reset (rst_n, asynchronous, active low) empties the queue and output, sets the cursor
// to row 0 cell 0 and loads the registers with address 60, width 128 and height 64.
`default_nettype none

module oled_text_cursor_command_generator_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    input  wire logic         cmd_valid,
    output logic              cmd_stall,
    input  wire logic [3:0]   command,
    input  wire logic [3:0]   target_row,
    input  wire logic [4:0]   target_column,
    input  wire logic [63:0]  glyph_top,
    input  wire logic [63:0]  glyph_bottom,
    input  wire logic         glyph_tall,
    input  wire logic [7:0]   setting_value,
    output logic              txn_valid,
    input  wire logic         txn_stall,
    output logic [2:0]        transaction_kind,
    output logic [6:0]        bus_address,
    output logic [7:0]        command_byte,
    output logic [7:0]        argument_byte,
    output logic [63:0]       data_bytes,
    output logic [7:0]        zero_count,
    output logic              success,
    output logic              last
);

    logic [6:0] device_address_reg;
    logic [7:0] panel_width_reg;
    logic [6:0] panel_height_reg;

    otcg_pkg::geometry_t     geom;
    otcg_pkg::queue_status_t qstat;
    otcg_pkg::job_t          push_job;
    otcg_pkg::job_t          pop_job;
    logic                    push;
    logic                    pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= 7'd60;
            panel_width_reg    <= 8'd128;
            panel_height_reg   <= 7'd64;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                otcg_pkg::REG_DEVICE_ADDRESS: device_address_reg <= cfg_data[6:0];
                otcg_pkg::REG_PANEL_WIDTH:    panel_width_reg    <= cfg_data;
                otcg_pkg::REG_PANEL_HEIGHT:   panel_height_reg   <= cfg_data[6:0];
                default:                      ;
            endcase
        end
    end

    // Page and cell counts, capped at the supported maximum.
    always_comb
    begin
        geom.pages = (panel_height_reg[6:3] > 4'(otcg_pkg::MAX_PAGES))
                   ? 4'(otcg_pkg::MAX_PAGES) : panel_height_reg[6:3];
        geom.cells = (panel_width_reg[7:3] > 5'(otcg_pkg::MAX_CELLS))
                   ? 5'(otcg_pkg::MAX_CELLS) : panel_width_reg[7:3];
    end

    otcg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .command       (command),
        .target_row    (target_row),
        .target_column (target_column),
        .glyph_top     (glyph_top),
        .glyph_bottom  (glyph_bottom),
        .glyph_tall    (glyph_tall),
        .setting_value (setting_value),
        .geom          (geom),
        .qstat         (qstat),
        .push          (push),
        .job           (push_job)
    );

    otcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .qstat    (qstat)
    );

    otcg_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .qstat            (qstat),
        .pop_job          (pop_job),
        .pop              (pop),
        .device_address   (device_address_reg),
        .txn_valid        (txn_valid),
        .txn_stall        (txn_stall),
        .transaction_kind (transaction_kind),
        .bus_address      (bus_address),
        .command_byte     (command_byte),
        .argument_byte    (argument_byte),
        .data_bytes       (data_bytes),
        .zero_count       (zero_count),
        .success          (success),
        .last             (last)
    );

    // A transfer that reports no transaction is always the only one of its command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (txn_valid && (transaction_kind == otcg_pkg::KIND_NONE)) |-> last)
        else $error("none transfer without last");

    // Fill lengths never exceed a full row of the widest panel.
    assert property (@(posedge clk) disable iff (!rst_n)
        txn_valid |-> (zero_count <= 8'(otcg_pkg::MAX_CELLS * 8)))
        else $error("zero fill longer than a row");

    // Two-byte commands only carry the contrast opcode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (txn_valid && (transaction_kind == otcg_pkg::KIND_CMD2))
            |-> (command_byte == otcg_pkg::OP_CONTRAST))
        else $error("two-byte command with wrong opcode");

    // The sequencer never fetches from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("job fetched from empty queue");

endmodule

`default_nettype wire

@@ test/oled_text_cursor_command_generator_checker.sv @@
`timescale 1ns / 100ps

module oled_text_cursor_command_generator_checker import otcg_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    input  wire logic         cmd_valid,
    input  wire logic         cmd_stall,
    input  wire logic [3:0]   command,
    input  wire logic [3:0]   target_row,
    input  wire logic [4:0]   target_column,
    input  wire logic [63:0]  glyph_top,
    input  wire logic [63:0]  glyph_bottom,
    input  wire logic         glyph_tall,
    input  wire logic [7:0]   setting_value,
    input  wire logic         txn_valid,
    input  wire logic         txn_stall,
    input  wire logic [2:0]   transaction_kind,
    input  wire logic [6:0]   bus_address,
    input  wire logic [7:0]   command_byte,
    input  wire logic [7:0]   argument_byte,
    input  wire logic [63:0]  data_bytes,
    input  wire logic [7:0]   zero_count,
    input  wire logic         success,
    input  wire logic         last,
    output int                mismatch_count,
    output int                outstanding
);

    // A single command never expands into more bus transactions than this.
    localparam int MAX_TXNS = 19;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  address;
        logic [7:0]  opcode;
        logic [7:0]  argument;
        logic [63:0] data;
        logic [7:0]  zeros;
        logic        ok;
        logic        is_last;
    } bus_txn_t;

    // Shadow copy of the registers and the text cursor.
    logic [6:0] dev_addr;
    logic [7:0] width_px;
    logic [6:0] height_px;
    logic [2:0] cur_row;
    logic [4:0] cur_cell;

    // Transactions still owed by the block, oldest first, and those of the current command.
    bus_txn_t expected_txns[$];
    bus_txn_t cmd_txns[$];

    initial mismatch_count = 0;

    function automatic int unsigned page_count();
        int unsigned p;
        p = height_px >> 3;
        return (p > MAX_PAGES) ? MAX_PAGES : p;
    endfunction

    function automatic int unsigned cell_count();
        int unsigned c;
        c = width_px >> 3;
        return (c > MAX_CELLS) ? MAX_CELLS : c;
    endfunction

    function automatic void add_txn(kind_t kind, logic [7:0] opcode, logic [7:0] argument,
                                    logic [63:0] data, logic [7:0] zeros);
        bus_txn_t t;
        if (cmd_txns.size() < MAX_TXNS)
        begin
            t.kind = kind;
            t.address = dev_addr;
            t.opcode = opcode;
            t.argument = argument;
            t.data = data;
            t.zeros = zeros;
            t.ok = 1'b0;
            t.is_last = 1'b0;
            cmd_txns.push_back(t);
        end
    endfunction

    function automatic void add_cmd(logic [7:0] opcode);
        add_txn(KIND_CMD1, opcode, 8'h00, 64'h0, 8'h00);
    endfunction

    function automatic void add_fill(int unsigned n);
        add_txn(KIND_ZERO, 8'h00, 8'h00, 64'h0, 8'(n));
    endfunction

    // Page address followed by the low and high column nibbles of a cell.
    function automatic void add_position(int unsigned row, int unsigned cell_idx);
        add_cmd({PAGE_NIBBLE, 4'(row)});
        add_cmd({COL_LOW_NIBBLE, 4'((cell_idx << 3) & 15)});
        add_cmd({COL_HIGH_NIBBLE, 4'(cell_idx >> 1)});
    endfunction

    // One-based move where zero keeps the current coordinate.
    function automatic bit go_to(int unsigned row, int unsigned col);
        int unsigned nr;
        int unsigned nc;
        if (row > page_count() || col > cell_count())
            return 1'b0;
        nr = (row == 0) ? cur_row : row - 1;
        nc = (col == 0) ? cur_cell : col - 1;
        add_position(nr, nc);
        cur_row = 3'(nr);
        cur_cell = 5'(nc);
        return 1'b1;
    endfunction

    function automatic bit advance_rows(int unsigned step);
        int unsigned nr;
        nr = int'(cur_row) + step;
        if (nr >= page_count())
            return 1'b0;
        add_cmd({PAGE_NIBBLE, 4'(nr)});
        add_cmd({COL_LOW_NIBBLE, 4'h0});
        add_cmd({COL_HIGH_NIBBLE, 4'h0});
        cur_row = 3'(nr);
        cur_cell = 5'd0;
        return 1'b1;
    endfunction

    function automatic int unsigned rest_bytes();
        if (cur_cell >= cell_count())
            return 0;
        return (cell_count() - cur_cell) << 3;
    endfunction

    // Expands one accepted command into the transactions it must produce.
    task automatic expand_command(input logic [3:0] op, input logic [3:0] row,
                                  input logic [4:0] col, input logic [63:0] top,
                                  input logic [63:0] bottom, input logic tall,
                                  input logic [7:0] val);
        bit ok;
        int unsigned n;
        int unsigned r0;
        int unsigned c0;
        cmd_txns.delete();
        ok = 1'b1;
        case (op)
            CMD_MOVE:
                ok = go_to(row, col);
            CMD_NEXT_ROW:
                ok = advance_rows(1);
            CMD_NEXT_ROW_DOUBLE:
                ok = advance_rows(2);
            CMD_DRAW:
                if (cur_cell >= cell_count())
                    ok = 1'b0;
                else
                begin
                    // A tall glyph writes the page below first, then returns to the cursor.
                    if (tall)
                    begin
                        add_cmd({PAGE_NIBBLE, 4'(cur_row) + 4'd1});
                        add_txn(KIND_DATA, 8'h00, 8'h00, bottom, 8'h00);
                        add_position(cur_row, cur_cell);
                    end
                    add_txn(KIND_DATA, 8'h00, 8'h00, top, 8'h00);
                    cur_cell = cur_cell + 5'd1;
                end
            CMD_CLEAR_ROW, CMD_CLEAR_ROW_DOUBLE:
                if (!go_to(row, 1))
                    ok = 1'b0;
                else
                begin
                    add_fill(cell_count() << 3);
                    if (op == CMD_CLEAR_ROW_DOUBLE)
                    begin
                        if (go_to(int'(row) + 1, 1))
                            add_fill(cell_count() << 3);
                        else
                            ok = 1'b0;
                    end
                end
            CMD_CLEAR_REST, CMD_CLEAR_REST_DOUBLE:
            begin
                // Failing cursor moves are skipped without rejecting the command.
                n = rest_bytes();
                r0 = int'(cur_row) + 1;
                c0 = int'(cur_cell) + 1;
                add_fill(n);
                if (op == CMD_CLEAR_REST_DOUBLE)
                begin
                    void'(go_to(r0 + 1, c0));
                    add_fill(n);
                end
                void'(go_to(r0, c0));
            end
            CMD_CLEAR_ALL:
            begin
                for (int unsigned pg = 0; pg < page_count(); pg++)
                begin
                    add_cmd({PAGE_NIBBLE, 4'(pg)});
                    add_fill(cell_count() << 3);
                end
                void'(go_to(1, 1));
            end
            CMD_POWER:
                add_cmd(val[0] ? OP_DISPLAY_ON : OP_DISPLAY_OFF);
            CMD_INVERT:
                add_cmd(val[0] ? OP_INVERT_ON : OP_INVERT_OFF);
            CMD_FLIP:
                if (val[0])
                begin
                    add_cmd(OP_REMAP_ON);
                    add_cmd(OP_SCAN_DEC);
                end
                else
                begin
                    add_cmd(OP_REMAP_OFF);
                    add_cmd(OP_SCAN_INC);
                end
            CMD_CONTRAST:
                add_txn(KIND_CMD2, OP_CONTRAST, val, 64'h0, 8'h00);
            default:
                ok = 1'b0;
        endcase

        // A command with nothing to send still reports its outcome once.
        if (cmd_txns.size() == 0)
            add_txn(KIND_NONE, 8'h00, 8'h00, 64'h0, 8'h00);
        foreach (cmd_txns[k])
        begin
            cmd_txns[k].ok = ok;
            cmd_txns[k].is_last = (k == cmd_txns.size() - 1);
            expected_txns.push_back(cmd_txns[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_transfer();
        bus_txn_t want;
        if (expected_txns.size() == 0)
        begin
            $error("transfer with nothing expected: kind %0d, command_byte 0x%0h",
                   transaction_kind, command_byte);
            mismatch_count++;
        end
        else
        begin
            want = expected_txns.pop_front();
            check_field("transaction_kind", want.kind, transaction_kind);
            check_field("bus_address", want.address, bus_address);
            check_field("command_byte", want.opcode, command_byte);
            check_field("argument_byte", want.argument, argument_byte);
            check_field("data_bytes", want.data, data_bytes);
            check_field("zero_count", want.zeros, zero_count);
            check_field("success", want.ok, success);
            check_field("last", want.is_last, last);
        end
    endtask

    // Results are compared before the command of the same edge is expanded.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr = 7'd60;
            width_px = 8'd128;
            height_px = 7'd64;
            cur_row = 3'd0;
            cur_cell = 5'd0;
            expected_txns.delete();
            outstanding = 0;
        end
        else
        begin
            if (txn_valid && !txn_stall)
                check_transfer();
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DEVICE_ADDRESS: dev_addr = cfg_data[6:0];
                    REG_PANEL_WIDTH:    width_px = cfg_data;
                    REG_PANEL_HEIGHT:   height_px = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (cmd_valid && !cmd_stall)
                expand_command(command, target_row, target_column, glyph_top, glyph_bottom,
                               glyph_tall, setting_value);
            outstanding = expected_txns.size();
        end
    end

endmodule

@@ test/oled_text_cursor_command_generator_top_tb.sv @@
`timescale 1ns / 100ps

module oled_text_cursor_command_generator_top_tb import otcg_pkg::*; ;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 57;
    localparam int HOLD_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 20;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_write;
    logic [1:0]   cfg_index;
    logic [7:0]   cfg_data;
    logic         cmd_valid;
    logic         cmd_stall;
    logic [3:0]   command;
    logic [3:0]   target_row;
    logic [4:0]   target_column;
    logic [63:0]  glyph_top;
    logic [63:0]  glyph_bottom;
    logic         glyph_tall;
    logic [7:0]   setting_value;
    logic         txn_valid;
    logic         txn_stall;
    logic [2:0]   transaction_kind;
    logic [6:0]   bus_address;
    logic [7:0]   command_byte;
    logic [7:0]   argument_byte;
    logic [63:0]  data_bytes;
    logic [7:0]   zero_count;
    logic         success;
    logic         last;

    int mismatch_count;
    int outstanding;
    int quiet_cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_pending = 1'b0;

    oled_text_cursor_command_generator_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .command          (command),
        .target_row       (target_row),
        .target_column    (target_column),
        .glyph_top        (glyph_top),
        .glyph_bottom     (glyph_bottom),
        .glyph_tall       (glyph_tall),
        .setting_value    (setting_value),
        .txn_valid        (txn_valid),
        .txn_stall        (txn_stall),
        .transaction_kind (transaction_kind),
        .bus_address      (bus_address),
        .command_byte     (command_byte),
        .argument_byte    (argument_byte),
        .data_bytes       (data_bytes),
        .zero_count       (zero_count),
        .success          (success),
        .last             (last)
    );

    oled_text_cursor_command_generator_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .command          (command),
        .target_row       (target_row),
        .target_column    (target_column),
        .glyph_top        (glyph_top),
        .glyph_bottom     (glyph_bottom),
        .glyph_tall       (glyph_tall),
        .setting_value    (setting_value),
        .txn_valid        (txn_valid),
        .txn_stall        (txn_stall),
        .transaction_kind (transaction_kind),
        .bus_address      (bus_address),
        .command_byte     (command_byte),
        .argument_byte    (argument_byte),
        .data_bytes       (data_bytes),
        .zero_count       (zero_count),
        .success          (success),
        .last             (last),
        .mismatch_count   (mismatch_count),
        .outstanding      (outstanding)
    );

    always #1 clk = ~clk;

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (txn_valid && !txn_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off that backs up the command queue.
    initial
    begin
        txn_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                txn_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            txn_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Offers one command and returns once its transfer has taken place.
    task automatic send_cmd(input logic [3:0] op, input logic [3:0] row, input logic [4:0] col,
                            input logic [63:0] top, input logic [63:0] bottom,
                            input logic tall, input logic [7:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        command <= op;
        target_row <= row;
        target_column <= col;
        glyph_top <= top;
        glyph_bottom <= bottom;
        glyph_tall <= tall;
        setting_value <= val;
        do @(posedge clk); while (cmd_stall !== 1'b0);
    endtask

    // Random command, biased toward draws and moves so the cursor travels the panel.
    task automatic send_random();
        int pick;
        logic [3:0] op;
        logic [3:0] row;
        logic [4:0] col;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            op = CMD_DRAW;
        else if (pick < 40)
            op = CMD_MOVE;
        else if (pick < 45)
            op = 4'($urandom_range(CMD_CONTRAST + 1, 4'hF));
        else
            op = 4'($urandom_range(CMD_MOVE, CMD_CONTRAST));
        row = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
        col = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
        send_cmd(op, row, col, {$urandom, $urandom}, {$urandom, $urandom},
                 1'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drops valid and waits until every owed transaction has come out.
    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Corner cases at the reset geometry of eight pages by sixteen cells.
    task automatic run_directed();
        send_cmd(CMD_MOVE, 4'd8, 5'd16, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_DRAW, 4'd0, 5'd0, '1, '0, 1'b1, 8'h00);
        send_cmd(CMD_DRAW, 4'd0, 5'd0, '0, '1, 1'b0, 8'h00);
        send_cmd(CMD_CLEAR_REST, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_NEXT_ROW, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_MOVE, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_MOVE, 4'd9, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_MOVE, 4'd1, 5'd1, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_NEXT_ROW_DOUBLE, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_NEXT_ROW, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_DRAW, 4'd0, 5'd0, 64'h0123_4567_89AB_CDEF, '1, 1'b0, 8'h00);
        send_cmd(CMD_CLEAR_REST_DOUBLE, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_CLEAR_ROW, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_CLEAR_ROW_DOUBLE, 4'd8, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_CLEAR_ROW_DOUBLE, 4'd2, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_MOVE, 4'd7, 5'd1, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_NEXT_ROW_DOUBLE, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_CLEAR_ALL, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_POWER, 4'd0, 5'd0, '0, '0, 1'b0, 8'hFE);
        send_cmd(CMD_POWER, 4'd0, 5'd0, '0, '0, 1'b0, 8'h01);
        send_cmd(CMD_INVERT, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_INVERT, 4'd0, 5'd0, '0, '0, 1'b0, 8'hFF);
        send_cmd(CMD_FLIP, 4'd0, 5'd0, '0, '0, 1'b0, 8'h01);
        send_cmd(CMD_FLIP, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_CONTRAST, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
        send_cmd(CMD_CONTRAST, 4'd0, 5'd0, '0, '0, 1'b0, 8'hFF);
        send_cmd(CMD_CONTRAST + 4'd1, 4'hF, 5'h1F, '1, '1, 1'b1, 8'hFF);
        send_cmd(4'hF, 4'd0, 5'd0, '0, '0, 1'b0, 8'h00);
    endtask

    // Main sequence: reset, directed commands, then random phases with new geometry.
    initial
    begin
        logic [6:0] addr;
        logic [7:0] panel_w;
        logic [6:0] panel_h;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_DEVICE_ADDRESS;
        cfg_data = 8'h00;
        cmd_valid = 1'b0;
        command = CMD_MOVE;
        target_row = 4'd0;
        target_column = 5'd0;
        glyph_top = 64'h0;
        glyph_bottom = 64'h0;
        glyph_tall = 1'b0;
        setting_value = 8'h00;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    addr = 7'h2A;
                    panel_w = 8'd128;
                    panel_h = 7'd64;
                end
                1:
                begin
                    addr = 7'h7F;
                    panel_w = 8'd8;
                    panel_h = 7'd8;
                end
                2:
                begin
                    addr = 7'h00;
                    panel_w = 8'd128;
                    panel_h = 7'd64;
                end
                3:
                begin
                    addr = 7'($urandom);
                    panel_w = 8'($urandom_range(8, 128));
                    panel_h = 7'($urandom_range(8, 64));
                end
                4:
                begin
                    addr = 7'($urandom);
                    panel_w = 8'($urandom_range(1, 16) * 8);
                    panel_h = 7'($urandom_range(1, 8) * 8);
                end
                default:
                begin
                    addr = 7'd60;
                    panel_w = 8'd128;
                    panel_h = 7'd64;
                end
            endcase
            write_reg(REG_DEVICE_ADDRESS, {1'b0, addr});
            write_reg(REG_PANEL_WIDTH, panel_w);
            write_reg(REG_PANEL_HEIGHT, {1'b0, panel_h});

            // Idle pattern cycles through none, sender, receiver and both.
            case (phase % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 74;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 74;
                    hold_pending = 1'b1;
                end
                default:
                begin
                    tx_idle_pct = 17;
                    rx_stall_pct = 17;
                end
            endcase

            repeat (ITEMS_PER_PHASE) send_random();
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
